[sv/par_pkg.sv]
// Package for the prefix affinity ranker: sizes, function codes, word types.
// No dependencies.
package par_pkg;

  localparam int NumAgents = 8;
  localparam int MaxBytes  = 8192;
  localparam int ListMax   = 8;
  localparam int AgentW    = 3;
  localparam int LenW      = 14;
  localparam int PosW      = 13;
  localparam int IdxW      = 3;
  localparam int CntW      = 4;
  localparam int AddrW     = AgentW + PosW;

  localparam logic [1:0] FuncStore = 2'd0;
  localparam logic [1:0] FuncCand  = 2'd1;
  localparam logic [1:0] FuncQuery = 2'd2;

  typedef struct packed {
    logic [1:0]        func;
    logic [AgentW-1:0] agent;
    logic [7:0]        data_byte;
    logic              last;
  } in_word_t;

  typedef struct packed {
    logic [AgentW-1:0] ranked_agent;
    logic [LenW-1:0]   score;
    logic [IdxW-1:0]   rank;
    logic              last_in_run;
  } out_word_t;

endpackage

[sv/prefix_affinity_ranker.sv]
// Prefix affinity ranker top level: prefix memory, candidate compare and rank emission.
// Depends on par_pkg.
// Store, candidate and unused words finish in idle. A query word reads and compares each
// candidate in turn; a last query word adds a pairwise rank pass, one output per candidate
// (held on out_stall), then a clear. One word at a time; no candidates: straight to clear.
// Reset clears lengths, list, positions and min_match; the prefix memory is not cleared.
module prefix_affinity_ranker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  par_pkg::in_word_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output par_pkg::out_word_t   out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [13:0]          cfg_data
);
  import par_pkg::*;

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StRead = 6'b000010,
    StCmp  = 6'b000100,
    StRank = 6'b001000,
    StEmit = 6'b010000,
    StDone = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [7:0] mem [NumAgents*MaxBytes];
  logic [7:0] rd_q;

  logic [LenW-1:0] min_q;
  logic [LenW-1:0] slen_q [NumAgents];
  logic [LenW-1:0] spos_q, qpos_q;
  logic [AgentW-1:0] cand_q [ListMax];
  logic [CntW-1:0] cnt_q;
  logic [LenW-1:0] mlen_q [ListMax];
  logic [ListMax-1:0] still_q;
  in_word_t w_q;
  logic [IdxW-1:0] i_q, j_q;
  logic [IdxW-1:0] pos_q [ListMax];
  logic [IdxW-1:0] emit_q;
  out_word_t out_q;
  logic out_v_q;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_q != StIdle);
  assign out_valid = out_v_q;
  assign out_data  = out_q;

  wire acc = in_valid & ~in_stall;
  wire [CntW-1:0] nm1 = cnt_q - CntW'(1);
  wire [AgentW-1:0] ca = cand_q[i_q];
  wire [AddrW-1:0] rd_addr = {ca, qpos_q[PosW-1:0]};
  wire [AddrW-1:0] wr_addr = {in_data.agent, spos_q[PosW-1:0]};

  function automatic logic [LenW-1:0] sc(input logic [LenW-1:0] m, input logic [LenW-1:0] t,
                                         input logic [CntW-1:0] n);
    sc = (n >= CntW'(2) && m < t) ? '0 : m;
  endfunction

  always_ff @(posedge clk_i) begin
    if (acc && in_data.func == FuncStore && spos_q < LenW'(MaxBytes))
      mem[wr_addr] <= in_data.data_byte;
    rd_q <= mem[rd_addr];
  end

  // score of i vs j; j ranks ahead of i if higher score, or equal and earlier
  wire [LenW-1:0] si = sc(mlen_q[i_q], min_q, cnt_q);
  wire [LenW-1:0] sj = sc(mlen_q[j_q], min_q, cnt_q);
  wire ahead = (sj > si) || (sj == si && j_q < i_q);
  wire [IdxW-1:0] pi = pos_q[i_q];
  logic [IdxW-1:0] hit_k;
  always_comb begin
    hit_k = '0;
    for (int k = 0; k < ListMax; k++)
      if (pos_q[k] == emit_q && CntW'(k) < cnt_q) hit_k = IdxW'(k);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (acc && in_data.func == FuncQuery)
                state_d = (cnt_q != '0) ? StRead : (in_data.last ? StDone : StIdle);
      StRead: state_d = StCmp;
      StCmp:  state_d = (CntW'(i_q) == nm1) ? (w_q.last ? StRank : StIdle) : StRead;
      StRank: if (CntW'(i_q) == nm1 && CntW'(j_q) == nm1) state_d = StEmit;
      StEmit: if (!out_v_q || !out_stall)
                if (CntW'(emit_q) == nm1) state_d = StDone;
      StDone: if (!out_v_q || !out_stall) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      min_q <= '0; spos_q <= '0; qpos_q <= '0; cnt_q <= '0;
      still_q <= '1; i_q <= '0; j_q <= '0; emit_q <= '0; out_v_q <= 1'b0;
      for (int k = 0; k < NumAgents; k++) slen_q[k] <= '0;
      for (int k = 0; k < ListMax; k++) begin
        mlen_q[k] <= '0; pos_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid) min_q <= cfg_data;
      if (out_v_q && !out_stall) out_v_q <= 1'b0;
      case (state_q)
        StIdle: if (acc) begin
          w_q <= in_data; i_q <= '0;
          case (in_data.func)
            FuncStore: begin
              if (in_data.last) begin
                slen_q[in_data.agent] <= (spos_q < LenW'(MaxBytes)) ? spos_q + 1'b1 : spos_q;
                spos_q <= '0;
              end else if (spos_q < LenW'(MaxBytes)) spos_q <= spos_q + 1'b1;
            end
            FuncCand: if (cnt_q < CntW'(ListMax)) begin
              cand_q[cnt_q[IdxW-1:0]] <= in_data.agent;
              mlen_q[cnt_q[IdxW-1:0]] <= '0;
              still_q[cnt_q[IdxW-1:0]] <= (qpos_q == '0);
              cnt_q <= cnt_q + 1'b1;
            end
            FuncQuery: if (cnt_q == '0) begin
              if (qpos_q < LenW'(MaxBytes)) qpos_q <= qpos_q + 1'b1;
            end
            default: ;
          endcase
        end
        StCmp: begin
          if (still_q[i_q] && qpos_q < slen_q[ca] && qpos_q < LenW'(MaxBytes)
              && rd_q == w_q.data_byte)
            mlen_q[i_q] <= mlen_q[i_q] + 1'b1;
          else still_q[i_q] <= 1'b0;
          i_q <= i_q + 1'b1;
          if (CntW'(i_q) == nm1) begin
            if (qpos_q < LenW'(MaxBytes)) qpos_q <= qpos_q + 1'b1;
            i_q <= '0; j_q <= '0; pos_q[0] <= '0;
          end
        end
        StRank: begin
          pos_q[i_q] <= (j_q == '0 ? '0 : pi) + (ahead ? IdxW'(1) : '0);
          if (CntW'(j_q) == nm1) begin
            j_q <= '0; i_q <= i_q + 1'b1;
          end else j_q <= j_q + 1'b1;
          if (state_d == StEmit) emit_q <= '0;
        end
        StEmit: if (!out_v_q || !out_stall) begin
          out_v_q <= 1'b1;
          out_q.ranked_agent <= cand_q[hit_k];
          out_q.score <= sc(mlen_q[hit_k], min_q, cnt_q);
          out_q.rank <= emit_q;
          out_q.last_in_run <= (CntW'(emit_q) == nm1);
          emit_q <= emit_q + 1'b1;
        end
        StDone: if (!out_v_q || !out_stall) begin
          cnt_q <= '0; qpos_q <= '0; still_q <= '1;
          for (int k = 0; k < ListMax; k++) mlen_q[k] <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule

[sv/par_checker.sv]
// Port-level checker for the prefix affinity ranker, bound to the top level.
// Depends on par_pkg.
module par_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input par_pkg::out_word_t out_data
);
  import par_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("out word changed");
  a_rank_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_stall && !out_data.last_in_run |=> !out_valid ||
      out_data.rank == $past(out_data.rank) + 3'd1) else $error("rank skipped");
  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> in_stall) else $error("input open during emit");
  a_desc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_stall && !out_data.last_in_run ##1 out_valid |->
      out_data.score <= $past(out_data.score)) else $error("not descending");
endmodule

bind prefix_affinity_ranker par_checker u_par_checker (.*);
